>>> hdl/fpaa_pkg.sv
// ----------------------------------------------------------------------------
// fpaa_pkg
// Shared types, constants and the angle ROM for the arccos / arcsin core.
// ----------------------------------------------------------------------------
package fpaa_pkg;

    localparam logic        CMD_ACOS    = 1'b0;
    localparam logic        CMD_ASIN    = 1'b1;

    localparam logic [14:0] SEG_B_START = 15'd30720;
    localparam logic [14:0] SEG_C_START = 15'd32736;
    localparam logic [7:0]  SEG_B_BASE  = 8'd62;
    localparam logic [7:0]  SEG_C_BASE  = 8'd126;
    localparam logic [7:0]  IDX_MAX     = 8'd129;
    localparam int          ROM_DEPTH   = 131;

    typedef enum logic [1:0] {
        SEG_A,
        SEG_B,
        SEG_C
    } t_seg;

    // stage 1 word: segment decode done
    typedef struct packed {
        logic       valid;
        logic       cmd;
        logic       neg;
        t_seg       seg;
        logic [7:0] idx;
        logic [8:0] frac;
    } t_s1;

    // stage 3 word: product of slope and fraction
    typedef struct packed {
        logic        valid;
        logic        cmd;
        logic        neg;
        t_seg        seg;
        logic        falling;
        logic [15:0] a;
        logic [24:0] prod;
    } t_s3;

    localparam logic [15:0] ANGLE_ROM [0:ROM_DEPTH-1] = '{
        16'h8000, 16'h7eba, 16'h7d74, 16'h7c2d, 16'h7ae7, 16'h79a0, 16'h7859, 16'h7711,
        16'h75c9, 16'h7480, 16'h7337, 16'h71ec, 16'h70a1, 16'h6f55, 16'h6e07, 16'h6cb8,
        16'h6b68, 16'h6a17, 16'h68c4, 16'h6770, 16'h661a, 16'h64c1, 16'h6367, 16'h620b,
        16'h60ad, 16'h5f4c, 16'h5de9, 16'h5c83, 16'h5b1a, 16'h59ae, 16'h583e, 16'h56cb,
        16'h5555, 16'h53db, 16'h525c, 16'h50d9, 16'h4f51, 16'h4dc5, 16'h4c32, 16'h4a9a,
        16'h48fc, 16'h4757, 16'h45ab, 16'h43f7, 16'h423a, 16'h4075, 16'h3ea5, 16'h3ccb,
        16'h3ae5, 16'h38f1, 16'h36ef, 16'h34dc, 16'h32b7, 16'h307d, 16'h2e2b, 16'h2bbd,
        16'h292e, 16'h2678, 16'h2391, 16'h206c, 16'h1cf6, 16'h0000, 16'h1cf6, 16'h1cbb,
        16'h1c80, 16'h1c45, 16'h1c08, 16'h1bcc, 16'h1b8f, 16'h1b51, 16'h1b13, 16'h1ad4,
        16'h1a95, 16'h1a55, 16'h1a14, 16'h19d3, 16'h1992, 16'h194f, 16'h190c, 16'h18c9,
        16'h1884, 16'h183f, 16'h17f9, 16'h17b3, 16'h176b, 16'h1723, 16'h16da, 16'h1690,
        16'h1645, 16'h15f9, 16'h15ac, 16'h155e, 16'h150f, 16'h14be, 16'h146d, 16'h141a,
        16'h13c6, 16'h1370, 16'h1319, 16'h12c1, 16'h1267, 16'h120b, 16'h11ad, 16'h114e,
        16'h10ec, 16'h1088, 16'h1022, 16'h0fb9, 16'h0f4d, 16'h0ede, 16'h0e6c, 16'h0df7,
        16'h0d7d, 16'h0d00, 16'h0c7d, 16'h0bf4, 16'h0b66, 16'h0ad0, 16'h0a31, 16'h0989,
        16'h08d3, 16'h080e, 16'h0734, 16'h063d, 16'h0518, 16'h039a, 16'h039a, 16'h031e,
        16'h028c, 16'h01cd, 16'h0000
    };

    function automatic logic [15:0] rom_word(input logic [7:0] idx);
        logic [15:0] w;
        if (idx < 8'(ROM_DEPTH)) begin
            w = ANGLE_ROM[idx];
        end else begin
            w = 16'h0000;
        end
        return w;
    endfunction

endpackage

>>> hdl/fpaa_interp.sv
// ----------------------------------------------------------------------------
// fpaa_interp
// ROM lookup of the two neighbouring entries, then slope times fraction.
// ----------------------------------------------------------------------------
module fpaa_interp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  fpaa_pkg::t_s1 i_s1,
    output fpaa_pkg::t_s3 o_s3
);
    import fpaa_pkg::*;

    typedef struct packed {
        logic        valid;
        logic        cmd;
        logic        neg;
        t_seg        seg;
        logic [8:0]  frac;
        logic [15:0] a;
        logic [15:0] b;
    } t_s2;

    t_s2         r_s2, n_s2;
    t_s3         r_s3, n_s3;
    logic [15:0] w_diff;

    // stage 2: registered ROM read pair
    always_comb begin
        n_s2.valid = i_s1.valid;
        n_s2.cmd   = i_s1.cmd;
        n_s2.neg   = i_s1.neg;
        n_s2.seg   = i_s1.seg;
        n_s2.frac  = i_s1.frac;
        n_s2.a     = rom_word(i_s1.idx);
        n_s2.b     = rom_word(i_s1.idx + 8'd1);
    end

    // stage 3: magnitude of slope times fraction
    always_comb begin
        w_diff       = (r_s2.a >= r_s2.b) ? (r_s2.a - r_s2.b) : (r_s2.b - r_s2.a);
        n_s3.valid   = r_s2.valid;
        n_s3.cmd     = r_s2.cmd;
        n_s3.neg     = r_s2.neg;
        n_s3.seg     = r_s2.seg;
        n_s3.falling = (r_s2.a >= r_s2.b);
        n_s3.a       = r_s2.a;
        n_s3.prod    = 25'(w_diff) * 25'(r_s2.frac);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
        end else begin
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;

endmodule

>>> hdl/fixed_point_arccos_arcsin_core.sv
// ----------------------------------------------------------------------------
// fixed_point_arccos_arcsin_core
// An accepted start reaches the o_valid strobe through r_s1, r_s2, r_s3 and r_out_vld.
// Throughput: one word per cycle; busy is never raised, four stages in flight.
// Stages: segment decode, ROM pair read, 16x9 multiply, shift and fold.
// Reset clears the stage valid bits only; no clearing pass, usable at once.
// ----------------------------------------------------------------------------
module fixed_point_arccos_arcsin_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cmd,
    input  logic signed [15:0] i_x,
    output logic               o_valid,
    output logic        [15:0] o_angle
);
    import fpaa_pkg::*;

    t_s1         r_s1, n_s1;
    t_s3         w_s3;
    logic        r_out_vld;
    logic [15:0] r_angle, n_angle;
    logic [15:0] w_abs;
    logic [14:0] w_mag;
    logic [14:0] w_off;
    logic [7:0]  w_idx;
    logic [15:0] w_step;
    logic [15:0] w_r;

    assign busy = 1'b0;

    // stage 1: magnitude and segment decode
    always_comb begin
        w_abs = i_x[15] ? (16'h0000 - i_x) : i_x;
        // most negative input has no 15-bit magnitude: clamp to full scale
        w_mag = w_abs[15] ? 15'h7fff : w_abs[14:0];
        n_s1.valid = start & ~busy;
        n_s1.cmd   = i_cmd;
        n_s1.neg   = i_x[15];
        if (w_mag >= SEG_C_START) begin
            w_off     = w_mag - SEG_C_START;
            n_s1.seg  = SEG_C;
            w_idx     = SEG_C_BASE + {6'd0, w_off[4:3]};
            n_s1.frac = {6'd0, w_off[2:0]};
        end else if (w_mag >= SEG_B_START) begin
            w_off     = w_mag - SEG_B_START;
            n_s1.seg  = SEG_B;
            w_idx     = SEG_B_BASE + {2'd0, w_off[10:5]};
            n_s1.frac = {4'd0, w_off[4:0]};
        end else begin
            w_off     = w_mag;
            n_s1.seg  = SEG_A;
            w_idx     = {2'd0, w_off[14:9]};
            n_s1.frac = w_off[8:0];
        end
        n_s1.idx = (w_idx > IDX_MAX) ? IDX_MAX : w_idx;
    end

    fpaa_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (r_s1),
        .o_s3    (w_s3)
    );

    // stage 4: scale product back by the segment step, then fold
    always_comb begin
        case (w_s3.seg)
            SEG_C:   w_step = w_s3.prod[18:3];
            SEG_B:   w_step = w_s3.prod[20:5];
            SEG_A:   w_step = w_s3.prod[24:9];
            default: w_step = w_s3.prod[24:9];
        endcase
        w_r = w_s3.falling ? (w_s3.a - w_step) : (w_s3.a + w_step);
        if (w_s3.cmd == CMD_ACOS) begin
            n_angle = w_s3.neg ? (16'hffff - w_r) : w_r;
        end else begin
            n_angle = w_s3.neg ? (w_r - 16'h8000) : (16'h7fff - w_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_s1      <= n_s1;
            r_out_vld <= w_s3.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_angle <= n_angle;
    end

    assign o_valid = r_out_vld;
    assign o_angle = r_angle;

    a_strobe_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##4 o_valid)
        else $error("accepted word did not produce a strobe");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##4 !o_valid)
        else $error("strobe without an accepted word");

    a_acos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && (i_cmd == CMD_ACOS) && !i_x[15]) |-> ##4 (o_angle <= 16'h8000))
        else $error("arccos of a non-negative input beyond a quarter turn");

endmodule

>>> dv/tb_fixed_point_arccos_arcsin_core.sv
// ----------------------------------------------------------------------------
// tb_fixed_point_arccos_arcsin_core
// Self-checking bench for the table-interpolated arccos / arcsin core. Words
// come from a queue filled up front: a directed set over the segment edges,
// the sign extremes and both commands, then random words weighted towards the
// fine segments. Each accepted word is run through a local table model, and
// every o_valid strobe is checked in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_fixed_point_arccos_arcsin_core;

    import fpaa_pkg::*;

    localparam int N_DIRECTED     = 24;
    localparam int N_RANDOM       = 1150;
    localparam int PIPE_DEPTH     = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    localparam logic [16:0] MAG_MAX    = 17'd32767;
    localparam logic [16:0] MAG_FINE   = 17'd30720;
    localparam logic [16:0] MAG_FINEST = 17'd32736;

    // arccos magnitude table, three segments: step 512, step 32, step 8
    localparam logic [15:0] ACOS_TABLE [0:130] = '{
        16'h8000, 16'h7eba, 16'h7d74, 16'h7c2d, 16'h7ae7, 16'h79a0, 16'h7859, 16'h7711,
        16'h75c9, 16'h7480, 16'h7337, 16'h71ec, 16'h70a1, 16'h6f55, 16'h6e07, 16'h6cb8,
        16'h6b68, 16'h6a17, 16'h68c4, 16'h6770, 16'h661a, 16'h64c1, 16'h6367, 16'h620b,
        16'h60ad, 16'h5f4c, 16'h5de9, 16'h5c83, 16'h5b1a, 16'h59ae, 16'h583e, 16'h56cb,
        16'h5555, 16'h53db, 16'h525c, 16'h50d9, 16'h4f51, 16'h4dc5, 16'h4c32, 16'h4a9a,
        16'h48fc, 16'h4757, 16'h45ab, 16'h43f7, 16'h423a, 16'h4075, 16'h3ea5, 16'h3ccb,
        16'h3ae5, 16'h38f1, 16'h36ef, 16'h34dc, 16'h32b7, 16'h307d, 16'h2e2b, 16'h2bbd,
        16'h292e, 16'h2678, 16'h2391, 16'h206c, 16'h1cf6, 16'h0000, 16'h1cf6, 16'h1cbb,
        16'h1c80, 16'h1c45, 16'h1c08, 16'h1bcc, 16'h1b8f, 16'h1b51, 16'h1b13, 16'h1ad4,
        16'h1a95, 16'h1a55, 16'h1a14, 16'h19d3, 16'h1992, 16'h194f, 16'h190c, 16'h18c9,
        16'h1884, 16'h183f, 16'h17f9, 16'h17b3, 16'h176b, 16'h1723, 16'h16da, 16'h1690,
        16'h1645, 16'h15f9, 16'h15ac, 16'h155e, 16'h150f, 16'h14be, 16'h146d, 16'h141a,
        16'h13c6, 16'h1370, 16'h1319, 16'h12c1, 16'h1267, 16'h120b, 16'h11ad, 16'h114e,
        16'h10ec, 16'h1088, 16'h1022, 16'h0fb9, 16'h0f4d, 16'h0ede, 16'h0e6c, 16'h0df7,
        16'h0d7d, 16'h0d00, 16'h0c7d, 16'h0bf4, 16'h0b66, 16'h0ad0, 16'h0a31, 16'h0989,
        16'h08d3, 16'h080e, 16'h0734, 16'h063d, 16'h0518, 16'h039a, 16'h039a, 16'h031e,
        16'h028c, 16'h01cd, 16'h0000
    };

    typedef struct {
        logic        cmd;
        logic [15:0] x;
        int unsigned gap;    // idle cycles after this word is taken
        bit          drain;  // hold this word until the pipe is empty
    } t_angle_req;

    typedef struct {
        logic        cmd;
        logic [15:0] x;
        logic [15:0] angle;
    } t_angle_due;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start   = 1'b0;
    logic               i_cmd   = 1'b0;
    logic signed [15:0] i_x     = '0;
    logic               busy;
    logic               o_valid;
    logic        [15:0] o_angle;

    t_angle_req  pending_words [$];
    t_angle_due  angle_due [$];
    int unsigned idle_left;
    int unsigned words_sent;
    int unsigned acos_sent;
    int unsigned asin_sent;
    int unsigned seg_hits [3];
    int unsigned angles_checked;
    int unsigned mismatches;
    int unsigned idle_cycles;

    fixed_point_arccos_arcsin_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .i_x     (i_x),
        .o_valid (o_valid),
        .o_angle (o_angle)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [15:0] predict_angle(input logic cmd, input logic [15:0] x,
                                                  output t_seg seg);
        logic        neg;
        logic [16:0] mag;
        logic [16:0] off;
        logic [7:0]  base;
        logic [7:0]  idx;
        int unsigned sh;
        logic [16:0] msk;
        logic [15:0] a;
        logic [15:0] b;
        logic [31:0] frac;
        logic [31:0] prod;
        logic [15:0] r;
        neg = x[15];
        mag = neg ? (17'h10000 - {1'b0, x}) : {1'b0, x};
        // -32768 has no positive twin: treat as -32767
        if (mag > MAG_MAX) begin
            mag = MAG_MAX;
        end
        if (mag >= MAG_FINEST) begin
            seg = SEG_C; base = 8'd126; sh = 3; msk = 17'h007; off = mag - MAG_FINEST;
        end else if (mag >= MAG_FINE) begin
            seg = SEG_B; base = 8'd62;  sh = 5; msk = 17'h01f; off = mag - MAG_FINE;
        end else begin
            seg = SEG_A; base = 8'd0;   sh = 9; msk = 17'h1ff; off = mag;
        end
        idx = base + 8'(off >> sh);
        if (idx > 8'd129) begin
            idx = 8'd129;
        end
        a    = ACOS_TABLE[idx];
        b    = ACOS_TABLE[idx + 8'd1];
        frac = 32'(off & msk);
        if (a >= b) begin
            prod = 32'(a - b) * frac;
            r    = a - 16'(prod >> sh);
        end else begin
            prod = 32'(b - a) * frac;
            r    = a + 16'(prod >> sh);
        end
        if (cmd == CMD_ACOS) begin
            return neg ? (16'hffff - r) : r;
        end
        return neg ? (r - 16'h8000) : (16'h7fff - r);
    endfunction

    // driver: one word at a time from the pending queue
    always @(posedge i_clk) begin
        t_angle_due due;
        t_angle_req req;
        t_seg       seg;
        if (!i_rst_n) begin
            start     <= 1'b0;
            idle_left <= 0;
        end else begin
            if (start && !busy) begin
                due.cmd   = i_cmd;
                due.x     = i_x;
                due.angle = predict_angle(i_cmd, i_x, seg);
                angle_due.push_back(due);
                words_sent++;
                seg_hits[int'(seg)]++;
                if (i_cmd == CMD_ASIN) begin
                    asin_sent++;
                end else begin
                    acos_sent++;
                end
            end
            if (start && busy) begin
                // word not taken yet, hold it
            end else if (idle_left != 0) begin
                start     <= 1'b0;
                idle_left <= idle_left - 1;
            end else if (pending_words.size() != 0 &&
                         !(pending_words[0].drain && angle_due.size() != 0)) begin
                req = pending_words.pop_front();
                start     <= 1'b1;
                i_cmd     <= req.cmd;
                i_x       <= req.x;
                idle_left <= req.gap;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        t_angle_due due;
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                if (angle_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("ERROR: angle %h strobed with nothing outstanding", o_angle);
                    end
                end else begin
                    due = angle_due.pop_front();
                    angles_checked++;
                    if (o_angle !== due.angle) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("ERROR: cmd %0d x %h: angle expected %h, got %h",
                                     due.cmd, due.x, due.angle, o_angle);
                        end
                    end
                end
            end
            if ((start && !busy) || o_valid === 1'b1) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        logic [15:0] edge_x [12];
        int          bounds [6];
        t_angle_req  req;
        int          mag;
        int unsigned pick;
        bit          quiet;
        edge_x = '{16'h0000, 16'h0001, 16'h7fff, 16'h8000, 16'h8001, 16'hffff,
                   16'd30719, 16'd30720, 16'd32735, 16'd32736,
                   16'(-30720), 16'(-32736)};
        bounds = '{0, 512, 30720, 32736, 32767, 32768};
        for (int k = 0; k < N_DIRECTED; k++) begin
            req.cmd   = (k % 2 == 0) ? CMD_ACOS : CMD_ASIN;
            req.x     = edge_x[k / 2];
            req.gap   = $urandom_range(0, 11);
            req.drain = 1'b0;
            pending_words.push_back(req);
        end
        for (int k = 0; k < N_RANDOM; k++) begin
            // every third block of 100 runs back to back
            quiet = ((k / 100) % 3 == 0);
            pick  = $urandom_range(0, 9);
            if (pick < 4) begin
                req.x = 16'($urandom);
            end else begin
                if (pick < 7) begin
                    mag = $urandom_range(30720, 32767);
                end else if (pick < 9) begin
                    mag = $urandom_range(32736, 32767);
                end else begin
                    mag = bounds[$urandom_range(0, 5)] + $urandom_range(0, 2) - 1;
                    if (mag < 0) begin
                        mag = 0;
                    end
                end
                req.x = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
            end
            req.cmd   = $urandom_range(0, 1) ? CMD_ASIN : CMD_ACOS;
            req.gap   = quiet ? 0 : $urandom_range(0, 11);
            req.drain = (k == 0 || k == N_RANDOM / 2);
            pending_words.push_back(req);
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || start || angle_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (2 * PIPE_DEPTH) @(negedge i_clk);

        $display("Run: %0d words (%0d arccos, %0d arcsin), %0d angles checked",
                 words_sent, acos_sent, asin_sent, angles_checked);
        $display("Segments coarse/fine/finest: %0d/%0d/%0d, errors: %0d",
                 seg_hits[int'(SEG_A)], seg_hits[int'(SEG_B)], seg_hits[int'(SEG_C)],
                 mismatches);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
